// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands used by the top-level RTL file. Define ASSERT_OFF
// to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a rising clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `ASSERT_PROP(lbl, clk, rst_n, !(cond), msg)

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== rtl/rgts_pkg.sv =====
// ----------------------------------------------------------------------------
// rgts_pkg
// Shared widths, command and status codes, and the table write-enable bundle
// of the rate group table sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rgts_pkg;

  // Field widths fixed by the item format
  localparam int unsigned LOC_W     = 10;
  localparam int unsigned RATE_W    = 32;
  localparam int unsigned SUM_W     = 48;
  localparam int unsigned FILL_W    = 11;
  localparam int unsigned CNT_OUT_W = 11;
  localparam int unsigned FRAC_W    = 32;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned STAT_W    = 3;

  // Number of distinct locations a command can address
  localparam int unsigned LOC_SPACE = 1 << LOC_W;

  // Default table depth
  localparam int unsigned SLOTS_DEF = 1024;

  // Stream payload widths
  localparam int unsigned S_DATA_W = 96;
  localparam int unsigned M_DATA_W = 104;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_UPDATE = 3'd2,
    CMD_QUERY  = 3'd3,
    CMD_CLEAR  = 3'd4,
    CMD_FILL   = 3'd5,
    CMD_SAMPLE = 3'd6,
    CMD_NOP    = 3'd7
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 3'd0,
    STAT_FULL   = 3'd1,
    STAT_EMPTY  = 3'd2,
    STAT_REJECT = 3'd3,
    STAT_RANGE  = 3'd4
  } status_e;

  // Write enables of the three table memories
  typedef struct packed {
    logic slot_loc;
    logic slot_rate;
    logic loc_map;
  } tbl_we_t;

endpackage

`default_nettype wire

// ===== rtl/rgts_table.sv =====
// ----------------------------------------------------------------------------
// rgts_table
// The three table memories: slot to location, slot to rate (two read ports)
// and location to slot. Synchronous, one write and registered reads each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgts_table import rgts_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF,
  localparam int unsigned SW        = $clog2(SLOTS),
  localparam int unsigned MAP_DEPTH = (SLOTS < LOC_SPACE) ? SLOTS : LOC_SPACE,
  localparam int unsigned MAP_AW    = $clog2(MAP_DEPTH)
) (
  input  wire logic              clk_i,
  input  wire tbl_we_t           we_i,
  // slot to location
  input  wire logic [SW-1:0]     sl_waddr_i,
  input  wire logic [LOC_W-1:0]  sl_wdata_i,
  input  wire logic [SW-1:0]     sl_raddr_i,
  output logic      [LOC_W-1:0]  sl_rdata_o,
  // slot to rate
  input  wire logic [SW-1:0]     sr_waddr_i,
  input  wire logic [RATE_W-1:0] sr_wdata_i,
  input  wire logic [SW-1:0]     sr_raddr_a_i,
  input  wire logic [SW-1:0]     sr_raddr_b_i,
  output logic      [RATE_W-1:0] sr_rdata_a_o,
  output logic      [RATE_W-1:0] sr_rdata_b_o,
  // location to slot
  input  wire logic [MAP_AW-1:0] mp_waddr_i,
  input  wire logic [SW-1:0]     mp_wdata_i,
  input  wire logic [MAP_AW-1:0] mp_raddr_i,
  output logic      [SW-1:0]     mp_rdata_o
);

  logic [LOC_W-1:0]  slot_loc_mem  [SLOTS];
  logic [RATE_W-1:0] slot_rate_mem [SLOTS];
  logic [SW-1:0]     loc_map_mem   [MAP_DEPTH];

  logic [LOC_W-1:0]  sl_rdata_q;
  logic [RATE_W-1:0] sr_rdata_a_q;
  logic [RATE_W-1:0] sr_rdata_b_q;
  logic [SW-1:0]     mp_rdata_q;

  // Slot to location
  always_ff @(posedge clk_i) begin
    if (we_i.slot_loc) begin
      slot_loc_mem[sl_waddr_i] <= sl_wdata_i;
    end
    sl_rdata_q <= slot_loc_mem[sl_raddr_i];
  end

  // Slot to rate, two read ports
  always_ff @(posedge clk_i) begin
    if (we_i.slot_rate) begin
      slot_rate_mem[sr_waddr_i] <= sr_wdata_i;
    end
    sr_rdata_a_q <= slot_rate_mem[sr_raddr_a_i];
    sr_rdata_b_q <= slot_rate_mem[sr_raddr_b_i];
  end

  // Location to slot
  always_ff @(posedge clk_i) begin
    if (we_i.loc_map) begin
      loc_map_mem[mp_waddr_i] <= mp_wdata_i;
    end
    mp_rdata_q <= loc_map_mem[mp_raddr_i];
  end

  assign sl_rdata_o   = sl_rdata_q;
  assign sr_rdata_a_o = sr_rdata_a_q;
  assign sr_rdata_b_o = sr_rdata_b_q;
  assign mp_rdata_o   = mp_rdata_q;

endmodule

`default_nettype wire

// ===== rtl/rate_group_table_sampler_top.sv =====
// ----------------------------------------------------------------------------
// rate_group_table_sampler_top
// One group of a composition-rejection sampler: dense slot table with reverse
// location map, occupancy count, saturating rate total and single sampling
// attempts against max_rate.
//
//   Channel   Direction  tuser       tdata
//   s_axis    in         cmd         loc, rate_in, fill_count, rand_frac,
//                                    rand_slot
//   m_axis    out        status      rate_out, total_rate, active_count,
//                                    picked_loc
//   cfg       in         -           max_rate (write only)
//
// Steps per command, with the result taken at once: insert, clear, no-op and
// failures found on decode go from decode to the response; sample reads the
// chosen slot; stale-location failures stop after the map lookup; query and
// remove read the map, then the slots; update adds a step for the new rate in
// the total; fill writes the N created slots, one slot a cycle. The result is
// loaded into the output register as the sequencer returns to idle.
// One command is worked on at a time; tready is high only when idle.
// A finished result waits in the output register; a stalled output holds the
// next command in its response state. Reset clears count, total and control;
// the memories need no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rate_group_table_sampler_top import rgts_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration
  input  wire logic                cfg_we_i,
  input  wire logic [RATE_W-1:0]   cfg_wdata_i,    // max_rate
  // command stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // loc[9:0], rate_in[41:10], fill_count[52:42], rand_frac[84:53],
  // rand_slot[94:85], zero pad[95]
  input  wire logic [S_DATA_W-1:0] s_axis_tdata,
  input  wire logic [CMD_W-1:0]    s_axis_tuser,   // cmd
  // result stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // rate_out[31:0], total_rate[79:32], active_count[90:80],
  // picked_loc[100:91], zero pad[103:101]
  output logic      [M_DATA_W-1:0] m_axis_tdata,
  output logic      [STAT_W-1:0]   m_axis_tuser    // status
);

  localparam int unsigned SW        = $clog2(SLOTS);
  localparam int unsigned CW        = $clog2(SLOTS + 1);
  localparam int unsigned MAP_DEPTH = (SLOTS < LOC_SPACE) ? SLOTS : LOC_SPACE;
  localparam int unsigned MAP_AW    = $clog2(MAP_DEPTH);
  localparam logic [31:0]   SLOTS_W = 32'(SLOTS);
  localparam logic [31:0]   MAP_W   = 32'(MAP_DEPTH);
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_EXEC = 7'b0000010,
    ST_MAP  = 7'b0000100,
    ST_SLOT = 7'b0001000,
    ST_ADD  = 7'b0010000,
    ST_FILL = 7'b0100000,
    ST_RESP = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Command fields held for the duration of the command
  cmd_e              cmd_q;
  logic [LOC_W-1:0]  loc_q;
  logic [RATE_W-1:0] rate_q;
  logic [CW-1:0]     fill_n_q;
  logic [LOC_W-1:0]  rslot_q;
  logic [2*RATE_W-1:0] prod_q;

  // Group state
  logic [RATE_W-1:0] max_rate_q;
  logic [CW-1:0]     occ_q, occ_d;
  logic [SUM_W-1:0]  sum_q, sum_d;

  // Working registers
  logic [SW-1:0]     slot_q, slot_d;
  logic [CW-1:0]     fill_idx_q, fill_idx_d;
  status_e           status_q, status_d;
  logic [RATE_W-1:0] rate_out_q, rate_out_d;
  logic [LOC_W-1:0]  picked_q, picked_d;

  // Output register
  logic                m_valid_q;
  logic [M_DATA_W-1:0] m_data_q;
  logic [STAT_W-1:0]   m_user_q;

  // Table port signals
  tbl_we_t           tbl_we;
  logic [SW-1:0]     sl_waddr, sl_raddr, sr_waddr, sr_raddr_a, sr_raddr_b;
  logic [LOC_W-1:0]  sl_wdata, sl_rdata;
  logic [RATE_W-1:0] sr_wdata, sr_rdata_a, sr_rdata_b;
  logic [MAP_AW-1:0] mp_waddr, mp_raddr;
  logic [SW-1:0]     mp_wdata, mp_rdata;

  logic              in_xfer;
  logic              out_load;
  logic [SW-1:0]     last_slot;
  logic [FILL_W-1:0] fill_in;
  logic [CW-1:0]     fill_sat;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  sum_inc, sum_dec;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_RESP) && (!m_valid_q || m_axis_tready);
  assign last_slot     = SW'(occ_q - 1'b1);

  // Saturate fill count at the table depth
  assign fill_in  = s_axis_tdata[52:42];
  assign fill_sat = (32'(fill_in) > SLOTS_W) ? SLOTS_C : CW'(fill_in);

  // Saturating total: add the command rate, subtract the rate read back
  assign sum_wide = {1'b0, sum_q} + (SUM_W + 1)'(rate_q);
  assign sum_inc  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
  assign sum_dec  = (SUM_W'(sr_rdata_a) > sum_q) ? '0 : sum_q - SUM_W'(sr_rdata_a);

  // Read addresses: map lookup by location, then slot reads
  assign mp_raddr   = MAP_AW'(loc_q);
  assign sr_raddr_a = (state_q == ST_MAP) ? mp_rdata : SW'(rslot_q);
  assign sr_raddr_b = last_slot;
  assign sl_raddr   = (state_q == ST_MAP) ? last_slot : SW'(rslot_q);

  // Sequencer and table writes
  always_comb begin
    state_d    = state_q;
    occ_d      = occ_q;
    sum_d      = sum_q;
    slot_d     = slot_q;
    fill_idx_d = fill_idx_q;
    status_d   = status_q;
    rate_out_d = rate_out_q;
    picked_d   = picked_q;
    tbl_we     = '0;
    sl_waddr   = SW'(occ_q);
    sl_wdata   = loc_q;
    sr_waddr   = SW'(occ_q);
    sr_wdata   = rate_q;
    mp_waddr   = MAP_AW'(loc_q);
    mp_wdata   = SW'(occ_q);

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d    = ST_EXEC;
          status_d   = STAT_OK;
          rate_out_d = '0;
          picked_d   = '0;
        end
      end

      ST_EXEC: begin
        state_d = ST_RESP;
        unique case (cmd_q) inside
          CMD_INSERT: begin
            if (occ_q == SLOTS_C) begin
              status_d = STAT_FULL;
            end else if (32'(loc_q) >= SLOTS_W) begin
              status_d = STAT_RANGE;
            end else begin
              // append at the end of the dense table
              tbl_we = '{slot_loc: 1'b1, slot_rate: 1'b1, loc_map: 1'b1};
              occ_d  = occ_q + 1'b1;
              sum_d  = sum_inc;
            end
          end
          CMD_REMOVE, CMD_UPDATE, CMD_QUERY: begin
            if (occ_q == '0) begin
              status_d = STAT_EMPTY;
            end else if (32'(loc_q) >= SLOTS_W) begin
              status_d = STAT_RANGE;
            end else begin
              state_d = ST_MAP;
            end
          end
          CMD_CLEAR: begin
            occ_d = '0;
            sum_d = '0;
          end
          CMD_FILL: begin
            fill_idx_d = '0;
            sum_d      = '0;
            state_d    = ST_FILL;
          end
          CMD_SAMPLE: begin
            if (occ_q == '0) begin
              status_d = STAT_EMPTY;
            end else if (CW'(rslot_q) >= occ_q || 32'(rslot_q) >= SLOTS_W) begin
              status_d = STAT_RANGE;
            end else begin
              state_d = ST_SLOT;
            end
          end
          default: begin
            // no-op: report the state unchanged
          end
        endcase
      end

      ST_MAP: begin
        // drop stale mappings, else read the mapped and the last slot
        if (CW'(mp_rdata) >= occ_q) begin
          status_d = STAT_RANGE;
          state_d  = ST_RESP;
        end else begin
          slot_d  = mp_rdata;
          state_d = ST_SLOT;
        end
      end

      ST_SLOT: begin
        state_d = ST_RESP;
        case (cmd_q)
          CMD_REMOVE: begin
            // move the last slot into the hole
            tbl_we.slot_loc  = 1'b1;
            tbl_we.slot_rate = 1'b1;
            tbl_we.loc_map   = (32'(sl_rdata) < MAP_W);
            sl_waddr = slot_q;
            sl_wdata = sl_rdata;
            sr_waddr = slot_q;
            sr_wdata = sr_rdata_b;
            mp_waddr = MAP_AW'(sl_rdata);
            mp_wdata = slot_q;
            occ_d    = occ_q - 1'b1;
            sum_d    = sum_dec;
          end
          CMD_UPDATE: begin
            tbl_we.slot_rate = 1'b1;
            sr_waddr   = slot_q;
            sum_d      = sum_dec;
            rate_out_d = rate_q;
            state_d    = ST_ADD;
          end
          CMD_QUERY: begin
            rate_out_d = sr_rdata_a;
          end
          default: begin
            // sampling attempt: max_rate * frac < rate * 2^32
            if (prod_q < {sr_rdata_a, {RATE_W{1'b0}}}) begin
              picked_d = sl_rdata;
            end else begin
              status_d = STAT_REJECT;
            end
          end
        endcase
      end

      ST_ADD: begin
        sum_d   = sum_inc;
        state_d = ST_RESP;
      end

      ST_FILL: begin
        if (fill_idx_q == fill_n_q) begin
          occ_d   = fill_n_q;
          state_d = ST_RESP;
        end else begin
          // one zero-rate slot per cycle, mapped to its own index
          tbl_we.slot_loc  = 1'b1;
          tbl_we.slot_rate = 1'b1;
          tbl_we.loc_map   = (32'(fill_idx_q) < MAP_W);
          sl_waddr   = SW'(fill_idx_q);
          sl_wdata   = LOC_W'(fill_idx_q);
          sr_waddr   = SW'(fill_idx_q);
          sr_wdata   = '0;
          mp_waddr   = MAP_AW'(fill_idx_q);
          mp_wdata   = SW'(fill_idx_q);
          fill_idx_d = fill_idx_q + 1'b1;
        end
      end

      ST_RESP: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and group state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      occ_q      <= '0;
      sum_q      <= '0;
      max_rate_q <= '1;
      m_valid_q  <= 1'b0;
      fill_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      occ_q      <= occ_d;
      sum_q      <= sum_d;
      fill_idx_q <= fill_idx_d;
      if (cfg_we_i) begin
        max_rate_q <= cfg_wdata_i;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Command capture, working registers and result payload
  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    status_q   <= status_d;
    rate_out_q <= rate_out_d;
    picked_q   <= picked_d;
    if (in_xfer) begin
      cmd_q    <= cmd_e'(s_axis_tuser);
      loc_q    <= s_axis_tdata[9:0];
      rate_q   <= s_axis_tdata[41:10];
      fill_n_q <= fill_sat;
      rslot_q  <= s_axis_tdata[94:85];
      prod_q   <= max_rate_q * s_axis_tdata[84:53];
    end
    if (out_load) begin
      m_data_q <= {3'b000, picked_q, CNT_OUT_W'(occ_q), sum_q, rate_out_q};
      m_user_q <= status_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  rgts_table #(
    .SLOTS (SLOTS)
  ) u_table (
    .clk_i        (clk_i),
    .we_i         (tbl_we),
    .sl_waddr_i   (sl_waddr),
    .sl_wdata_i   (sl_wdata),
    .sl_raddr_i   (sl_raddr),
    .sl_rdata_o   (sl_rdata),
    .sr_waddr_i   (sr_waddr),
    .sr_wdata_i   (sr_wdata),
    .sr_raddr_a_i (sr_raddr_a),
    .sr_raddr_b_i (sr_raddr_b),
    .sr_rdata_a_o (sr_rdata_a),
    .sr_rdata_b_o (sr_rdata_b),
    .mp_waddr_i   (mp_waddr),
    .mp_wdata_i   (mp_wdata),
    .mp_raddr_i   (mp_raddr),
    .mp_rdata_o   (mp_rdata)
  );

  // Checks
  `ASSERT_PROP(a_occ_bound, clk_i, rst_ni, occ_q <= SLOTS_C, "occupancy above table depth")
  `ASSERT_NEVER(a_idle_no_write, clk_i, rst_ni, (state_q == ST_IDLE) && (tbl_we != '0), "table write while idle")
  `ASSERT_PROP(a_slot_valid, clk_i, rst_ni, ((state_q == ST_SLOT) && (cmd_q != CMD_SAMPLE)) |-> (CW'(slot_q) < occ_q), "mapped slot beyond occupancy")
  `ASSERT_PROP(a_fill_bound, clk_i, rst_ni, (state_q == ST_FILL) |-> (fill_idx_q <= fill_n_q), "fill walk overran")
  `ASSERT_PROP(a_out_from_resp, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(state_q == ST_RESP), "result shown outside response")

endmodule

`default_nettype wire
